@@ rtl/sliding_window_median_top_defines.svh @@
// assertion macros shared by the checker of the sliding window median block
`ifndef SLIDING_WINDOW_MEDIAN_TOP_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk_i and idle while rst_ni is low
`define SWM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i and idle while rst_ni is low
`define SWM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/swm_pkg.sv @@
// shared types and constants of the sliding window median block
package swm_pkg;

  localparam int unsigned WS_W = 7;
  localparam logic [WS_W-1:0] WS_RESET = 7'd3;
  localparam int unsigned IO_W = 32;

  // what the front decided for one sample
  typedef struct packed {
    logic evict;
    logic emit;
  } swm_ctrl_t;

endpackage

@@ rtl/swm_queue.sv @@
// small first-in first-out queue with push/full and pop/empty sides
module swm_queue
  import swm_pkg::*;
#(
  parameter int unsigned DEPTH  = 2,
  parameter int unsigned DATA_W = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [DATA_W-1:0]            wdata_i,
  output logic                         full_o,
  input  logic                         pop_i,
  output logic [DATA_W-1:0]            rdata_o,
  output logic                         empty_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];
  assign count_o = count_q;

  always_comb begin
    wr_ptr_d = do_push ? wrap_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? wrap_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

@@ rtl/swm_front.sv @@
// front end: takes samples, keeps the arrival ring and decides eviction and output
module swm_front
  import swm_pkg::*;
#(
  parameter int unsigned WINDOW_MAX   = 64,
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_clear_i,
  input  logic [$clog2(WINDOW_MAX+1)-1:0]   w_eff_i,
  input  logic                              push_i,
  input  logic [IO_W-1:0]                   sample_i,
  output logic                              full_o,
  output logic                              item_valid_o,
  input  logic                              item_ready_i,
  output swm_ctrl_t                         item_ctrl_o,
  output logic signed [SAMPLE_WIDTH-1:0]    item_val_o,
  output logic signed [SAMPLE_WIDTH-1:0]    item_old_o
);

  localparam int unsigned IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned CNT_W = $clog2(WINDOW_MAX + 1);

  logic signed [SAMPLE_WIDTH-1:0] ring_q [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] val_q, old_q, val_in;
  swm_ctrl_t                      ctrl_q, ctrl_d;
  logic                           stage_valid_q, stage_valid_d;
  logic [IDX_W-1:0]               ptr_q, ptr_d, slot;
  logic [CNT_W-1:0]               fill_q, fill_d, slot_inc;
  logic                           accept;

  // low sample width bits taken from the port, zero fill above the port
  if (SAMPLE_WIDTH <= IO_W) begin : g_narrow
    assign val_in = sample_i[SAMPLE_WIDTH-1:0];
  end else begin : g_wide
    assign val_in = {{(SAMPLE_WIDTH - IO_W){1'b0}}, sample_i};
  end

  assign full_o       = stage_valid_q && !item_ready_i;
  assign accept       = push_i && !full_o;
  assign item_valid_o = stage_valid_q;
  assign item_ctrl_o  = ctrl_q;
  assign item_val_o   = val_q;
  assign item_old_o   = old_q;

  always_comb begin
    slot     = (CNT_W'(ptr_q) >= w_eff_i) ? '0 : ptr_q;
    slot_inc = CNT_W'(slot) + CNT_W'(1);
    ptr_d    = (slot_inc >= w_eff_i) ? '0 : IDX_W'(slot_inc);
    ctrl_d.evict = (fill_q >= w_eff_i);
    ctrl_d.emit  = ctrl_d.evict || ((fill_q + CNT_W'(1)) == w_eff_i);
    fill_d   = ctrl_d.evict ? fill_q : fill_q + CNT_W'(1);
    stage_valid_d = accept || (stage_valid_q && !item_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q         <= '0;
      fill_q        <= '0;
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
      if (cfg_clear_i) begin
        ptr_q  <= '0;
        fill_q <= '0;
      end else if (accept) begin
        ptr_q  <= ptr_d;
        fill_q <= fill_d;
      end
    end
  end

  // ring read before write: the old entry is the sample leaving the window
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ring_q[slot] <= val_in;
      old_q        <= ring_q[slot];
      val_q        <= val_in;
      ctrl_q       <= ctrl_d;
    end
  end

endmodule

@@ rtl/swm_back.sv @@
// back end: sorted cell row with evict and insert per cycle while not held back, and median select tree
module swm_back
  import swm_pkg::*;
#(
  parameter int unsigned WINDOW_MAX   = 64,
  parameter int unsigned SAMPLE_WIDTH = 32,
  parameter int unsigned OUT_DEPTH    = 4
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_clear_i,
  input  logic [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)-1:0] mid_i,
  input  logic                                   in_valid_i,
  input  swm_ctrl_t                              in_ctrl_i,
  input  logic signed [SAMPLE_WIDTH-1:0]         in_val_i,
  input  logic signed [SAMPLE_WIDTH-1:0]         in_old_i,
  output logic                                   in_pop_o,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]         out_count_i,
  output logic                                   out_push_o,
  output logic [IO_W-1:0]                        out_median_o
);

  localparam int unsigned IDX_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int unsigned OCNT_W = $clog2(OUT_DEPTH + 1);
  localparam int unsigned GRP    = 8;
  localparam int unsigned NG     = (WINDOW_MAX + GRP - 1) / GRP;
  localparam int unsigned HI_W   = (NG > 1) ? $clog2(NG) : 1;
  localparam int unsigned MX_W   = IDX_W + 3;

  logic signed [SAMPLE_WIDTH-1:0] cells_q [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] cells_d [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] t_val   [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] grp_q   [NG];
  logic signed [SAMPLE_WIDTH-1:0] grp_d   [NG];
  logic signed [SAMPLE_WIDTH-1:0] med_val;
  logic [WINDOW_MAX-1:0]          rm, gt_y, t_gt;
  logic [CNT_W-1:0]               n_q;
  logic [OCNT_W:0]                used;
  logic                           go, upd_q, sel_q;
  logic [MX_W-1:0]                m_x;
  logic [2:0]                     lo;
  logic [HI_W-1:0]                hi;

  // hold back while the result queue could not take everything in flight
  assign used = (OCNT_W + 1)'(out_count_i) + (OCNT_W + 1)'(upd_q) + (OCNT_W + 1)'(sel_q);
  assign go       = in_valid_i && (used < (OCNT_W + 1)'(OUT_DEPTH));
  assign in_pop_o = go;

  // per cell flags; cells beyond the fill count act as larger than anything
  for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_flag
    logic occ;
    assign occ     = (CNT_W'(j) < n_q);
    assign rm[j]   = in_ctrl_i.evict && (!occ || (cells_q[j] >= in_old_i));
    assign gt_y[j] = !occ || (cells_q[j] > in_val_i);
  end

  // row after removal of the leaving sample
  for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_rm
    if (j + 1 < WINDOW_MAX) begin : g_mid
      assign t_val[j] = rm[j] ? cells_q[j+1] : cells_q[j];
      assign t_gt[j]  = rm[j] ? gt_y[j+1] : gt_y[j];
    end else begin : g_last
      assign t_val[j] = cells_q[j];
      assign t_gt[j]  = rm[j] || gt_y[j];
    end
  end

  // insertion after any equal entries
  for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_ins
    if (j == 0) begin : g_first
      assign cells_d[j] = t_gt[j] ? in_val_i : t_val[j];
    end else begin : g_rest
      assign cells_d[j] = !t_gt[j]  ? t_val[j]   :
                          t_gt[j-1] ? t_val[j-1] : in_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      cells_q <= cells_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q   <= '0;
      upd_q <= 1'b0;
      sel_q <= 1'b0;
    end else begin
      upd_q <= go && in_ctrl_i.emit;
      sel_q <= upd_q;
      if (cfg_clear_i) begin
        n_q <= '0;
      end else if (go && !in_ctrl_i.evict) begin
        n_q <= n_q + CNT_W'(1);
      end
    end
  end

  // two level select of the median cell
  assign m_x = MX_W'(mid_i);
  assign lo  = m_x[2:0];
  assign hi  = HI_W'(m_x >> 3);

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if ((g * GRP + k) < WINDOW_MAX) begin
          if (lo == 3'(k)) begin
            grp_d[g] = cells_q[IDX_W'(g * GRP + k)];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  assign med_val    = grp_q[hi];
  assign out_push_o = sel_q;

  if (SAMPLE_WIDTH >= IO_W) begin : g_out_wide
    assign out_median_o = med_val[IO_W-1:0];
  end else begin : g_out_narrow
    assign out_median_o = {{(IO_W - SAMPLE_WIDTH){1'b0}}, med_val};
  end

endmodule

@@ rtl/sliding_window_median_top.sv @@
// top level of the streaming sliding window median filter
//
// streaming lower median over the last window_size samples (0 acts as 1, values above
// WINDOW_MAX saturate); a sample is taken on every clock edge with push high and full low,
// one per cycle sustained while the result queue does not back up, because the sorted cell
// row in the back end evicts the oldest sample and inserts the new one in one row update; a
// result passes the front stage with ring read, the decoupling queue, the cell update and the
// two level median select, and waits in a four entry result queue; no result comes out
// until the window has filled, and a write to the window size register restarts filling;
// nothing is cleared after reset beyond the counters, so there is no start-up sweep;
// configure only while no transaction is in flight
module sliding_window_median_top
  import swm_pkg::*;
#(
  parameter int unsigned WINDOW_MAX   = 64,
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // sample side
  input  logic             push,
  output logic             full,
  input  logic [IO_W-1:0]  sample_i,
  // result side
  output logic             empty,
  input  logic             pop,
  output logic [IO_W-1:0]  median_o,
  // window size register
  input  logic             cfg_we_i,
  input  logic [WS_W-1:0]  cfg_wdata_i
);

  localparam int unsigned IDX_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned CNT_W     = $clog2(WINDOW_MAX + 1);
  localparam int unsigned MID_DEPTH = 2;
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned CTRL_W    = $bits(swm_ctrl_t);
  localparam int unsigned MID_W     = CTRL_W + 2 * SAMPLE_WIDTH;
  localparam int unsigned OCNT_W    = $clog2(OUT_DEPTH + 1);

  logic [WS_W-1:0]                 window_size_q;
  logic [CNT_W-1:0]                w_eff;
  logic [IDX_W-1:0]                mid_idx;

  // front to queue
  logic                            f_valid, f_ready;
  swm_ctrl_t                       f_ctrl;
  logic signed [SAMPLE_WIDTH-1:0]  f_val, f_old;
  // queue to back
  logic [MID_W-1:0]                q_rdata;
  logic                            q_empty, q_full, q_pop;
  logic [$clog2(MID_DEPTH+1)-1:0]  q_count;
  swm_ctrl_t                       b_ctrl;
  logic signed [SAMPLE_WIDTH-1:0]  b_val, b_old;
  // back to result queue
  logic                            r_push, r_full;
  logic [IO_W-1:0]                 r_median;
  logic [OCNT_W-1:0]               r_count;

  // window size register, a write also restarts the window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= WS_RESET;
    end else if (cfg_we_i) begin
      window_size_q <= cfg_wdata_i;
    end
  end

  // effective window and position of the lower median in the sorted row
  always_comb begin
    priority if (window_size_q == '0) begin
      w_eff = CNT_W'(1);
    end else if (window_size_q > WINDOW_MAX) begin
      w_eff = CNT_W'(WINDOW_MAX);
    end else begin
      w_eff = CNT_W'(window_size_q);
    end
    mid_idx = IDX_W'((w_eff - CNT_W'(1)) >> 1);
  end

  swm_front #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_clear_i  (cfg_we_i),
    .w_eff_i      (w_eff),
    .push_i       (push),
    .sample_i     (sample_i),
    .full_o       (full),
    .item_valid_o (f_valid),
    .item_ready_i (f_ready),
    .item_ctrl_o  (f_ctrl),
    .item_val_o   (f_val),
    .item_old_o   (f_old)
  );

  assign f_ready = !q_full;

  // decoupling queue between classification and the sorted row
  swm_queue #(
    .DEPTH  (MID_DEPTH),
    .DATA_W (MID_W)
  ) u_mid_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .wdata_i ({f_ctrl, f_val, f_old}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  assign b_ctrl = swm_ctrl_t'(q_rdata[MID_W-1 -: CTRL_W]);
  assign b_val  = q_rdata[2*SAMPLE_WIDTH-1 -: SAMPLE_WIDTH];
  assign b_old  = q_rdata[SAMPLE_WIDTH-1:0];

  swm_back #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .OUT_DEPTH    (OUT_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_clear_i  (cfg_we_i),
    .mid_i        (mid_idx),
    .in_valid_i   (!q_empty && (q_count != '0)),
    .in_ctrl_i    (b_ctrl),
    .in_val_i     (b_val),
    .in_old_i     (b_old),
    .in_pop_o     (q_pop),
    .out_count_i  (r_count),
    .out_push_o   (r_push),
    .out_median_o (r_median)
  );

  // result queue; the back end only issues work it has room for, so r_full never blocks
  swm_queue #(
    .DEPTH  (OUT_DEPTH),
    .DATA_W (IO_W)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (r_push),
    .wdata_i (r_median),
    .full_o  (r_full),
    .pop_i   (pop && !r_full || pop),
    .rdata_o (median_o),
    .empty_o (empty),
    .count_o (r_count)
  );

endmodule

@@ rtl/swm_checker.sv @@
// port level checks of the sliding window median block and their binding
`include "sliding_window_median_top_defines.svh"

module swm_checker
  import swm_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            push,
  input logic            full,
  input logic            pop,
  input logic            empty,
  input logic [IO_W-1:0] median_o
);

  // a waiting result does not move until it is taken
  `SWM_ASSERT_NXT(a_result_held, !empty && !pop, !empty && $stable(median_o), "result changed while stalled")

  // the input side only backs up right after taking a sample
  `SWM_ASSERT_IMP(a_full_after_accept, $rose(full), $past(push && !full), "full rose without a transaction")

  // results only drain through the pop side
  `SWM_ASSERT_IMP(a_empty_after_pop, $rose(empty), $past(pop), "result lost without a pop")

endmodule

bind sliding_window_median_top swm_checker u_swm_checker (.*);
